### rtl/pec_pkg.sv
// ----------------------------------------------------------------------------
// pec_pkg
// Shared widths, constants and register indexes of the power estimating
// proportional drive controller.
// ----------------------------------------------------------------------------
package pec_pkg;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned SETPOINT_W = 10;
  localparam int unsigned GAIN_W   = 8;
  localparam int unsigned POWER_W  = 10;
  localparam int unsigned LEVEL_W  = 12;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  // The error magnitude is at most ten times the largest target.
  localparam int unsigned ERR_W  = 14;
  localparam int unsigned MUL_A_W = ERR_W;
  localparam int unsigned MUL_B_W = SAMPLE_W;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
  localparam int unsigned DVS_W   = 17;

  // Volts times 100, amps times 20, over 2000000 and then over 100 folds
  // into a single division of the raw product by 100000.
  localparam logic [DVS_W-1:0] POWER_DIVISOR = DVS_W'(100000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_NUM      = 3'd0,
    REG_GAIN_DEN      = 3'd1,
    REG_DAC_MAX       = 3'd2,
    REG_REM_LOW       = 3'd3,
    REG_REM_HIGH      = 3'd4,
    REG_CURRENT_LIMIT = 3'd5,
    REG_TEMP_LIMIT    = 3'd6,
    REG_BIPOLAR_MODE  = 3'd7
  } pec_reg_e;

  typedef enum logic {
    OP_CONTROL = 1'b0,
    OP_ZERO    = 1'b1
  } pec_op_e;

endpackage

### rtl/power_estimate_p_controller_unit.sv
// ----------------------------------------------------------------------------
// power_estimate_p_controller_unit
// Proportional drive controller that estimates power from one sample scan,
// steers the held drive level towards the target and clamps it.
//
//   channel   direction  handshake              contents
//   in        to block   in_valid_i/in_stall_o  op, five samples, target
//   out       from block out_valid_o/out_stall_i drive level, power, flags
//   cfg       to block   cfg_valid_i/cfg_ready_o register index and data
//
// A control request makes two passes, each through the serial multiplier and
// then the serial divider, the done of each unit starting the next, and then
// enters the finishing state, where its result is registered. A zero request
// goes straight to the finishing state. The input stays stalled until the
// result is registered, so the next request is accepted in the following
// cycle at the earliest.
// Reset clears the held level and loads the register reset values.
// A result waits in the output register while out_stall_i is high; the
// next request is accepted meanwhile, and the block holds its own result
// until the output register is free.
// ----------------------------------------------------------------------------
module power_estimate_p_controller_unit import pec_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  op_i,
  input  logic [SAMPLE_W-1:0]   volt_sample_i,
  input  logic [SAMPLE_W-1:0]   current_a_sample_i,
  input  logic [SAMPLE_W-1:0]   current_b_sample_i,
  input  logic [SAMPLE_W-1:0]   rem_sample_i,
  input  logic [SAMPLE_W-1:0]   temp_sample_i,
  input  logic [SETPOINT_W-1:0] target_watts_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [LEVEL_W-1:0]    drive_level_o,
  output logic [POWER_W-1:0]    power_dw_o,
  output logic                  rem_ok_o,
  output logic                  over_current_o,
  output logic                  over_temp_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_DIV_P,
    ST_MUL_G,
    ST_DIV_G,
    ST_FINISH
  } state_e;

  state_e state_q;

  logic [GAIN_W-1:0]   gain_num_q;
  logic [GAIN_W-1:0]   gain_den_q;
  logic [LEVEL_W-1:0]  dac_max_q;
  logic [SAMPLE_W-1:0] rem_low_q;
  logic [SAMPLE_W-1:0] rem_high_q;
  logic [SAMPLE_W-1:0] current_limit_q;
  logic [SAMPLE_W-1:0] temp_limit_q;
  logic                bipolar_mode_q;

  logic [LEVEL_W-1:0]  held_q;
  logic                op_q;
  logic [SETPOINT_W-1:0] target_q;
  logic [POWER_W-1:0]  power_q;
  logic                err_neg_q;
  logic                rem_ok_q;
  logic                over_current_q;
  logic                over_temp_q;

  logic                out_valid_q;
  logic [LEVEL_W-1:0]  out_level_q;
  logic [POWER_W-1:0]  out_power_q;
  logic                out_rem_ok_q;
  logic                out_over_current_q;
  logic                out_over_temp_q;

  logic                in_accept;
  logic                mul_start;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic                mul_done;
  logic [PROD_W-1:0]   mul_prod;
  logic                div_start;
  logic [DVS_W-1:0]    div_dvs;
  logic                div_done;
  logic [PROD_W-1:0]   div_quo;

  logic [POWER_W-1:0]  power_c;
  logic [ERR_W-1:0]    target_x10;
  logic                err_neg_c;
  logic [ERR_W-1:0]    err_mag_c;
  logic [PROD_W:0]     level_sum;
  logic [LEVEL_W-1:0]  level_dec;
  logic [LEVEL_W-1:0]  level_c;
  logic                out_free;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_num_q      <= GAIN_W'(1);
      gain_den_q      <= GAIN_W'(1);
      dac_max_q       <= '1;
      rem_low_q       <= '0;
      rem_high_q      <= '1;
      current_limit_q <= '1;
      temp_limit_q    <= '1;
      bipolar_mode_q  <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (pec_reg_e'(cfg_index_i))
        REG_GAIN_NUM:      gain_num_q      <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN_DEN:      gain_den_q      <= cfg_data_i[GAIN_W-1:0];
        REG_DAC_MAX:       dac_max_q       <= cfg_data_i[LEVEL_W-1:0];
        REG_REM_LOW:       rem_low_q       <= cfg_data_i[SAMPLE_W-1:0];
        REG_REM_HIGH:      rem_high_q      <= cfg_data_i[SAMPLE_W-1:0];
        REG_CURRENT_LIMIT: current_limit_q <= cfg_data_i[SAMPLE_W-1:0];
        REG_TEMP_LIMIT:    temp_limit_q    <= cfg_data_i[SAMPLE_W-1:0];
        REG_BIPOLAR_MODE:  bipolar_mode_q  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Error against ten times the target, kept as sign and magnitude.
  assign power_c    = div_quo[POWER_W-1:0];
  assign target_x10 = (ERR_W'(target_q) << 3) + (ERR_W'(target_q) << 1);
  assign err_neg_c  = (ERR_W'(power_c) > target_x10);
  assign err_mag_c  = err_neg_c ? (ERR_W'(power_c) - target_x10)
                                : (target_x10 - ERR_W'(power_c));

  assign mul_start = (in_accept && (op_i == OP_CONTROL)) ||
                     ((state_q == ST_DIV_P) && div_done);
  assign mul_a     = (state_q == ST_IDLE) ? MUL_A_W'(volt_sample_i) : err_mag_c;
  assign mul_b     = (state_q == ST_IDLE) ? current_a_sample_i : MUL_B_W'(gain_num_q);

  assign div_start = ((state_q == ST_MUL_P) || (state_q == ST_MUL_G)) && mul_done;
  assign div_dvs   = (state_q == ST_MUL_P) ? POWER_DIVISOR :
                     ((gain_den_q == '0) ? DVS_W'(1) : DVS_W'(gain_den_q));

  pec_serial_mul #(
    .A_W (MUL_A_W),
    .B_W (MUL_B_W)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  pec_serial_div #(
    .N_W (PROD_W),
    .D_W (DVS_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (mul_prod),
    .dvs_i   (div_dvs),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Apply the step to the held level and clamp it to the drive range.
  assign level_sum = (PROD_W + 1)'(div_quo) + (PROD_W + 1)'(held_q);
  assign level_dec = held_q - div_quo[LEVEL_W-1:0];

  always_comb begin
    if (op_q == OP_ZERO) begin
      level_c = '0;
    end else if (err_neg_q) begin
      if (div_quo > PROD_W'(held_q)) begin
        level_c = '0;
      end else if (level_dec > dac_max_q) begin
        level_c = dac_max_q;
      end else begin
        level_c = level_dec;
      end
    end else if (level_sum > (PROD_W + 1)'(dac_max_q)) begin
      level_c = dac_max_q;
    end else begin
      level_c = level_sum[LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= ST_IDLE;
      held_q             <= '0;
      op_q               <= 1'b0;
      target_q           <= '0;
      power_q            <= '0;
      err_neg_q          <= 1'b0;
      rem_ok_q           <= 1'b0;
      over_current_q     <= 1'b0;
      over_temp_q        <= 1'b0;
      out_valid_q        <= 1'b0;
      out_level_q        <= '0;
      out_power_q        <= '0;
      out_rem_ok_q       <= 1'b0;
      out_over_current_q <= 1'b0;
      out_over_temp_q    <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (state_q != ST_FINISH)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            op_q           <= op_i;
            target_q       <= target_watts_i;
            rem_ok_q       <= bipolar_mode_q ||
                              ((rem_sample_i >= rem_low_q) && (rem_sample_i <= rem_high_q));
            over_current_q <= (current_a_sample_i > current_limit_q) ||
                              (current_b_sample_i > current_limit_q);
            over_temp_q    <= (temp_sample_i > temp_limit_q);
            state_q        <= (op_i == OP_ZERO) ? ST_FINISH : ST_MUL_P;
          end
        end
        ST_MUL_P: begin
          if (mul_done) begin
            state_q <= ST_DIV_P;
          end
        end
        ST_DIV_P: begin
          if (div_done) begin
            power_q   <= power_c;
            err_neg_q <= err_neg_c;
            state_q   <= ST_MUL_G;
          end
        end
        ST_MUL_G: begin
          if (mul_done) begin
            state_q <= ST_DIV_G;
          end
        end
        ST_DIV_G: begin
          if (div_done) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            held_q             <= level_c;
            out_valid_q        <= 1'b1;
            out_level_q        <= level_c;
            out_power_q        <= (op_q == OP_ZERO) ? '0 : power_q;
            out_rem_ok_q       <= rem_ok_q;
            out_over_current_q <= over_current_q;
            out_over_temp_q    <= over_temp_q;
            state_q            <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign drive_level_o  = out_level_q;
  assign power_dw_o     = out_power_q;
  assign rem_ok_o       = out_rem_ok_q;
  assign over_current_o = out_over_current_q;
  assign over_temp_o    = out_over_temp_q;

endmodule

### rtl/pec_serial_mul.sv
// ----------------------------------------------------------------------------
// pec_serial_mul
// Shift and add multiplier that retires one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pec_serial_mul import pec_pkg::*; #(
  parameter int unsigned A_W = MUL_A_W,
  parameter int unsigned B_W = MUL_B_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output logic               done_o,
  output logic [A_W+B_W-1:0] prod_o
);

  localparam int unsigned P_W   = A_W + B_W;
  localparam int unsigned CNT_W = (B_W > 1) ? $clog2(B_W) : 1;

  logic [P_W-1:0]   acc_q, acc_d;
  logic [P_W-1:0]   mcand_q, mcand_d;
  logic [B_W-1:0]   mplier_q, mplier_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  always_comb begin
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    done_d   = 1'b0;
    if (start_i) begin
      acc_d    = '0;
      mcand_d  = P_W'(a_i);
      mplier_d = b_i;
      cnt_d    = '0;
      busy_d   = 1'b1;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d  = mcand_q << 1;
      mplier_d = mplier_q >> 1;
      cnt_d    = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(B_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

### rtl/pec_serial_div.sv
// ----------------------------------------------------------------------------
// pec_serial_div
// Restoring divider that develops one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pec_serial_div import pec_pkg::*; #(
  parameter int unsigned N_W = PROD_W,
  parameter int unsigned D_W = DVS_W
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [N_W-1:0] dvd_i,
  input  logic [D_W-1:0] dvs_i,
  output logic           done_o,
  output logic [N_W-1:0] quo_o
);

  localparam int unsigned CNT_W = (N_W > 1) ? $clog2(N_W) : 1;

  logic [D_W-1:0]   rem_q, rem_d;
  logic [N_W-1:0]   quo_q, quo_d;
  logic [D_W-1:0]   dvs_q, dvs_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [D_W:0]     rem_sh;
  logic [D_W:0]     rem_sub;
  logic             fits;

  assign rem_sh  = {rem_q, quo_q[N_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign fits    = (rem_sh >= {1'b0, dvs_q});

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dvd_i;
      dvs_d  = dvs_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? rem_sub[D_W-1:0] : rem_sh[D_W-1:0];
      quo_d = {quo_q[N_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(N_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### rtl/pec_checker.sv
// ----------------------------------------------------------------------------
// pec_checker
// Port level checks of the drive controller, bound to its top level.
// ----------------------------------------------------------------------------
module pec_checker import pec_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [LEVEL_W-1:0]  drive_level_o,
  input logic [POWER_W-1:0]  power_dw_o
);

  // A request keeps the input side busy in the cycle after it is taken.
  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input side free right after a request");

  // A new result only appears while a request was being worked on.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared with no request in progress");

  // The power estimate from twelve bit samples never exceeds 167 deciwatts.
  a_power_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (power_dw_o <= POWER_W'(167)))
    else $error("power estimate out of range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(drive_level_o)))
    else $error("stalled result changed");

endmodule

bind power_estimate_p_controller_unit pec_checker u_pec_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .drive_level_o (drive_level_o),
  .power_dw_o    (power_dw_o)
);
